/* design/multicast_subscriber_queues_defines.svh */
// assertion macros for the checker file msq_checker.sv
// no dependencies
`ifndef MULTICAST_SUBSCRIBER_QUEUES_DEFINES_SVH
`define MULTICAST_SUBSCRIBER_QUEUES_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MSQ_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define MSQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/msq_pkg.sv */
// shared types, codes and defaults for the multicast subscriber queues
// no dependencies
`default_nettype none

package msq_pkg;

  localparam int DEF_NUM_SUBSCRIBERS = 32;
  localparam int DEF_QUEUE_DEPTH     = 32;
  localparam int DEF_MESSAGE_BITS    = 64;

  localparam int KEY_W    = 16;
  localparam int MSG_W    = 64;
  localparam int EVICT_W  = 6;
  localparam int DROP_W   = 32;
  localparam int MAX_POPS = 32;

  typedef enum logic [1:0] {
    OP_ADD       = 2'd0,
    OP_REMOVE    = 2'd1,
    OP_BROADCAST = 2'd2,
    OP_DRAIN     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_ADD_WR,
    S_DR_RD,
    S_DR_EMIT,
    S_RESP
  } eng_state_t;

  typedef struct packed {
    op_t              op;
    logic             key_zero;
    logic [KEY_W-1:0] key;
    logic [MSG_W-1:0] msg;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic [MSG_W-1:0]   msg;
    logic               last;
    logic [EVICT_W-1:0] evicted;
    logic [DROP_W-1:0]  dropped;
  } res_t;

endpackage

`default_nettype wire

/* design/msq_front.sv */
// front end: accepts input beats, decodes them and queues them for the engine
// depends on msq_pkg
`default_nettype none

module msq_front import msq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        operation,
  input  wire logic [KEY_W-1:0]  subscriber_key,
  input  wire logic [MSG_W-1:0]  message,
  output logic                   cmd_valid,
  output cmd_t                   cmd,
  input  wire logic              cmd_pop
);

  cmd_t       buf_q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;

  // two-entry command queue
  assign in_stall  = (count == 2'd2);
  assign accept    = in_valid && !in_stall;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = buf_q[rd_ptr];

  // decode and store the beat
  always_ff @(posedge clk) begin
    if (accept) begin
      buf_q[wr_ptr] <= '{op: op_t'(operation), key_zero: (subscriber_key == '0),
                         key: subscriber_key, msg: message};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) wr_ptr <= ~wr_ptr;
      if (cmd_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, accept} - {1'b0, cmd_pop};
    end
  end

endmodule

`default_nettype wire

/* design/msq_engine.sv */
// back end: slot table scan, per-slot ring queues and result register
// depends on msq_pkg
`default_nettype none

module msq_engine import msq_pkg::*; #(
  parameter int NUM_SUBSCRIBERS = DEF_NUM_SUBSCRIBERS,
  parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH,
  parameter int MESSAGE_BITS    = DEF_MESSAGE_BITS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  input  wire logic out_stall,
  output logic      out_valid,
  output res_t      out_res
);

  localparam int NUM   = NUM_SUBSCRIBERS;
  localparam int QD    = QUEUE_DEPTH;
  localparam int SW    = (NUM > 1) ? $clog2(NUM) : 1;
  localparam int QW    = $clog2(QD);
  localparam int FW    = $clog2(QD + 1);
  localparam int PW    = QW + 1;
  localparam int AW    = $clog2(NUM * QD);
  localparam int LIMIT = (QD < MAX_POPS) ? QD : MAX_POPS;
  localparam int NW    = $clog2(MAX_POPS + 1);

  // slot table and queue storage
  logic [KEY_W-1:0]        key_mem   [NUM];
  logic [QW-1:0]           head_mem  [NUM];
  logic [FW-1:0]           fill_mem  [NUM];
  logic [MESSAGE_BITS-1:0] store_mem [NUM*QD];

  eng_state_t state, state_next;

  logic [NUM-1:0]     active;
  logic [SW-1:0]      idx;
  logic               found;
  logic               have_free;
  logic [SW-1:0]      free_idx;
  status_t            res_status;
  logic [EVICT_W-1:0] res_evict;
  logic [DROP_W-1:0]  drop_cnt;
  logic [SW-1:0]      cur_slot;
  logic [KEY_W-1:0]   cur_key;
  logic [QW-1:0]      cur_head;
  logic [FW-1:0]      cur_fill;
  logic [NW-1:0]      pop_cnt;

  logic [KEY_W-1:0]        rd_key;
  logic [QW-1:0]           rd_head;
  logic [FW-1:0]           rd_fill;
  logic [MESSAGE_BITS-1:0] store_rd;

  logic               slot_we;
  logic [SW-1:0]      slot_waddr;
  logic [KEY_W-1:0]   slot_wkey;
  logic [QW-1:0]      slot_whead;
  logic [FW-1:0]      slot_wfill;
  logic               store_we;
  logic [AW-1:0]      store_waddr;
  logic [AW-1:0]      store_raddr;

  logic          out_free;
  logic          out_load;
  logic          hit;
  logic          scan_last;
  logic          q_full;
  logic [PW-1:0] pos_sum;
  logic [PW-1:0] wr_pos;
  logic [PW-1:0] head_inc;
  logic [QW-1:0] head_adv;
  logic          dr_last;

  // memory ports, registered reads
  always_ff @(posedge clk) begin
    rd_key   <= key_mem[idx];
    rd_head  <= head_mem[idx];
    rd_fill  <= fill_mem[idx];
    store_rd <= store_mem[store_raddr];
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      key_mem[slot_waddr]  <= slot_wkey;
      head_mem[slot_waddr] <= slot_whead;
      fill_mem[slot_waddr] <= slot_wfill;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_waddr] <= cmd.msg[MESSAGE_BITS-1:0];
    end
  end

  // per-slot decisions
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = out_free && ((state == S_DR_EMIT) || (state == S_RESP));
  assign hit       = active[idx] && (rd_key == cmd.key);
  assign scan_last = (idx == SW'(NUM - 1));
  assign q_full    = (rd_fill >= FW'(QD));
  assign pos_sum   = PW'(rd_head) + PW'(rd_fill);
  assign wr_pos    = (pos_sum >= PW'(QD)) ? (pos_sum - PW'(QD)) : pos_sum;
  assign head_inc  = PW'(cur_head) + PW'(1);
  assign head_adv  = (head_inc == PW'(QD)) ? '0 : head_inc[QW-1:0];
  assign dr_last   = (cur_fill == FW'(1)) || (pop_cnt == NW'(LIMIT - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.key_zero && (cmd.op != OP_BROADCAST)) state_next = S_RESP;
          else state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: state_next = S_SCAN_EV;
      S_SCAN_EV: begin
        if ((cmd.op == OP_DRAIN) && hit && (rd_fill != '0)) state_next = S_DR_RD;
        else if (scan_last) state_next = (cmd.op == OP_ADD) ? S_ADD_WR : S_RESP;
        else state_next = S_SCAN_RD;
      end
      S_ADD_WR: state_next = S_RESP;
      S_DR_RD:  state_next = S_DR_EMIT;
      S_DR_EMIT: begin
        if (out_free) state_next = dr_last ? S_IDLE : S_DR_RD;
      end
      S_RESP: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory write controls and command pop
  always_comb begin
    cmd_pop     = 1'b0;
    slot_we     = 1'b0;
    slot_waddr  = idx;
    slot_wkey   = rd_key;
    slot_whead  = rd_head;
    slot_wfill  = rd_fill + FW'(1);
    store_we    = 1'b0;
    store_waddr = AW'(idx) * AW'(QD) + AW'(wr_pos);
    store_raddr = AW'(cur_slot) * AW'(QD) + AW'(cur_head);
    unique case (state)
      S_SCAN_EV: begin
        if ((cmd.op == OP_BROADCAST) && active[idx] && !q_full) begin
          slot_we  = 1'b1;
          store_we = 1'b1;
        end
      end
      S_ADD_WR: begin
        slot_we    = !found && have_free;
        slot_waddr = free_idx;
        slot_wkey  = cmd.key;
        slot_whead = '0;
        slot_wfill = '0;
      end
      S_DR_EMIT: begin
        slot_we    = out_free;
        slot_waddr = cur_slot;
        slot_wkey  = cur_key;
        slot_whead = head_adv;
        slot_wfill = cur_fill - FW'(1);
        cmd_pop    = out_free && dr_last;
      end
      S_RESP: cmd_pop = out_free;
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      active    <= '0;
      drop_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // result register: load a new beat or release a taken one
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_SCAN_EV: begin
          if ((cmd.op == OP_REMOVE) && hit) active[idx] <= 1'b0;
          if ((cmd.op == OP_BROADCAST) && active[idx] && q_full) begin
            active[idx] <= 1'b0;
            if (drop_cnt != '1) drop_cnt <= drop_cnt + DROP_W'(1);
          end
        end
        S_ADD_WR: begin
          if (!found && have_free) active[free_idx] <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // scan bookkeeping and result beats
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        idx       <= '0;
        found     <= 1'b0;
        have_free <= 1'b0;
        res_evict <= '0;
        if (cmd.op == OP_DRAIN) res_status <= ST_EMPTY;
        else if ((cmd.op == OP_ADD) && cmd.key_zero && (&active)) res_status <= ST_FULL;
        else res_status <= ST_OK;
      end
      S_SCAN_EV: begin
        if (!scan_last) idx <= idx + SW'(1);
        if (cmd.op == OP_ADD) begin
          if (hit) found <= 1'b1;
          if (!active[idx]) begin
            have_free <= 1'b1;
            free_idx  <= idx;
          end
        end
        if ((cmd.op == OP_BROADCAST) && active[idx] && q_full && (res_evict != '1)) begin
          res_evict <= res_evict + EVICT_W'(1);
        end
        if ((cmd.op == OP_DRAIN) && hit && (rd_fill != '0)) begin
          cur_slot <= idx;
          cur_key  <= rd_key;
          cur_head <= rd_head;
          cur_fill <= rd_fill;
          pop_cnt  <= '0;
        end
      end
      S_ADD_WR: begin
        if (!found && !have_free) res_status <= ST_FULL;
      end
      S_DR_EMIT: begin
        if (out_free) begin
          out_res  <= '{status: ST_OK, msg: MSG_W'(store_rd), last: dr_last,
                        evicted: '0, dropped: drop_cnt};
          cur_head <= head_adv;
          cur_fill <= cur_fill - FW'(1);
          pop_cnt  <= pop_cnt + NW'(1);
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_res <= '{status: res_status, msg: '0, last: 1'b1,
                       evicted: res_evict, dropped: drop_cnt};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/multicast_subscriber_queues.sv */
// Multicast subscriber queues: a table of subscriber keys, each slot owning a
// ring queue of messages. Key-zero add, remove and drain skip the slot scan.
// Every other add, remove and broadcast scans all slots through one slot-table
// read port, with a read state and an evaluate state for each slot; a drain
// scans up to the first matching slot that holds messages, then pops each
// message through a read state and an emit state on the queue memory's read
// port. Two commands queue ahead of the engine and one result beat waits in
// the output register. No clearing pass runs after reset.
// depends on msq_pkg, msq_front, msq_engine
`default_nettype none

module multicast_subscriber_queues import msq_pkg::*; #(
  parameter int NUM_SUBSCRIBERS = DEF_NUM_SUBSCRIBERS,
  parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH,
  parameter int MESSAGE_BITS    = DEF_MESSAGE_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          operation,
  input  wire logic [KEY_W-1:0]    subscriber_key,
  input  wire logic [MSG_W-1:0]    message,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               status,
  output logic [MSG_W-1:0]         message_out,
  output logic                     last,
  output logic [EVICT_W-1:0]       evicted_now,
  output logic [DROP_W-1:0]        dropped_total
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  res_t out_res;

  // accept and decode
  msq_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .subscriber_key (subscriber_key),
    .message        (message),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  // execute
  msq_engine #(
    .NUM_SUBSCRIBERS (NUM_SUBSCRIBERS),
    .QUEUE_DEPTH     (QUEUE_DEPTH),
    .MESSAGE_BITS    (MESSAGE_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // result fields
  assign status        = out_res.status;
  assign message_out   = out_res.msg;
  assign last          = out_res.last;
  assign evicted_now   = out_res.evicted;
  assign dropped_total = out_res.dropped;

endmodule

`default_nettype wire

/* design/msq_checker.sv */
// port-level checks on the multicast subscriber queues, bound to the top level
// depends on msq_pkg and multicast_subscriber_queues_defines.svh
`default_nettype none
`include "multicast_subscriber_queues_defines.svh"

module msq_checker import msq_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [1:0]         status,
  input wire logic [MSG_W-1:0]   message_out,
  input wire logic               last,
  input wire logic [EVICT_W-1:0] evicted_now,
  input wire logic [DROP_W-1:0]  dropped_total
);

  logic              beat_held;
  logic              beat_taken;
  logic              quiet_last;
  logic              evict_seen;
  logic [DROP_W-1:0] drop_prev;

  // handshake and shape terms
  assign beat_held  = out_valid && out_stall;
  assign beat_taken = out_valid && !out_stall;
  assign quiet_last = (message_out == '0) && last;
  assign evict_seen = out_valid && (evicted_now != '0);

  // drop total seen at the previous edge
  always_ff @(posedge clk) begin
    drop_prev <= dropped_total;
  end

  // a stalled result beat holds
  `MSQ_ASSERT_NEXT(a_out_hold, clk, rst, beat_held, out_valid && $stable({status, message_out}))
  // full and empty answers are single, payload-free beats
  `MSQ_ASSERT_SAME(a_err_single, clk, rst, out_valid && (status != ST_OK), quiet_last)
  // evictions only show on a lone broadcast answer
  `MSQ_ASSERT_SAME(a_evict_shape, clk, rst, evict_seen, (status == ST_OK) && quiet_last)
  // drop total never goes down
  `MSQ_ASSERT_NEXT(a_drop_mono, clk, rst, beat_taken, !out_valid || (dropped_total >= drop_prev))

endmodule

bind multicast_subscriber_queues msq_checker u_msq_checker (.*);

`default_nettype wire

/* verif/multicast_subscriber_queues_test.sv */
// self-checking testbench for multicast_subscriber_queues: a table of directed
// beats, then random add/remove/broadcast/drain traffic checked against a predictor
// depends on msq_pkg and multicast_subscriber_queues
`timescale 1ns / 1ps

module multicast_subscriber_queues_test;
  import msq_pkg::*;

  localparam int SLOTS = 32;
  localparam int DEPTH = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    status_t           st;
    logic [MSG_W-1:0]  msg;
    logic              last;
    logic [EVICT_W-1:0] evicted;
    logic [DROP_W-1:0] dropped;
  } result_beat_t;

  typedef struct {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [MSG_W-1:0] msg;
    logic             typed;
    status_t          st;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] operation = 2'd0;
  logic [KEY_W-1:0] subscriber_key = '0;
  logic [MSG_W-1:0] message = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [MSG_W-1:0] message_out;
  logic last;
  logic [EVICT_W-1:0] evicted_now;
  logic [DROP_W-1:0] dropped_total;

  // predictor state
  logic [KEY_W-1:0] sub_keys [SLOTS];
  int unsigned      q_head [SLOTS];
  int unsigned      q_fill [SLOTS];
  logic [MSG_W-1:0] q_words [SLOTS][DEPTH];
  logic [DROP_W-1:0] drop_count;
  result_beat_t pending_results [$];

  int fails = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;
  logic [KEY_W-1:0] key_pool [48];

  dir_row_t dir_rows [0:19] = '{
    '{OP_DRAIN,     16'h0000, 64'h0, 1'b1, ST_EMPTY},
    '{OP_ADD,       16'h0000, 64'h0, 1'b1, ST_OK},
    '{OP_REMOVE,    16'h0000, 64'h0, 1'b1, ST_OK},
    '{OP_DRAIN,     16'hFFFF, 64'h0, 1'b1, ST_EMPTY},
    '{OP_ADD,       16'hFFFF, 64'h0, 1'b1, ST_OK},
    '{OP_ADD,       16'h0001, 64'h0, 1'b1, ST_OK},
    '{OP_ADD,       16'hFFFF, 64'h0, 1'b1, ST_OK},
    '{OP_BROADCAST, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_OK},
    '{OP_BROADCAST, 16'hFFFF, 64'h0, 1'b1, ST_OK},
    '{OP_BROADCAST, 16'h0000, 64'h0123_4567_89AB_CDEF, 1'b1, ST_OK},
    '{OP_DRAIN,     16'hFFFF, 64'h0, 1'b0, ST_OK},
    '{OP_DRAIN,     16'hFFFF, 64'h0, 1'b1, ST_EMPTY},
    '{OP_REMOVE,    16'h0001, 64'h0, 1'b1, ST_OK},
    '{OP_DRAIN,     16'h0001, 64'h0, 1'b1, ST_EMPTY},
    '{OP_ADD,       16'h0001, 64'h0, 1'b1, ST_OK},
    '{OP_DRAIN,     16'h0001, 64'h0, 1'b1, ST_EMPTY},
    '{OP_BROADCAST, 16'h0000, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, ST_OK},
    '{OP_REMOVE,    16'hFFFF, 64'h0, 1'b1, ST_OK},
    '{OP_BROADCAST, 16'h0000, 64'h5555_5555_5555_5555, 1'b1, ST_OK},
    '{OP_ADD,       16'h8000, 64'h0, 1'b1, ST_OK}
  };

  multicast_subscriber_queues DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .subscriber_key(subscriber_key), .message(message),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .message_out(message_out), .last(last),
    .evicted_now(evicted_now), .dropped_total(dropped_total)
  );

  always #6 clk = ~clk;

  function automatic result_beat_t make_beat(status_t st, logic [MSG_W-1:0] m,
                                             logic l, logic [EVICT_W-1:0] ev);
    result_beat_t b;
    b.st = st; b.msg = m; b.last = l; b.evicted = ev; b.dropped = drop_count;
    return b;
  endfunction

  // apply one command to the shadow table and queue the beats it yields
  task automatic apply_command(op_t op, logic [KEY_W-1:0] key, logic [MSG_W-1:0] msg);
    int open_slot;
    int slot;
    int pops;
    int unsigned pos;
    logic [EVICT_W-1:0] ev;
    logic [MSG_W-1:0] word;
    open_slot = -1;
    slot = -1;
    pops = 0;
    ev = '0;
    case (op)
      OP_ADD: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (sub_keys[i] == key) begin
            pending_results.push_back(make_beat(ST_OK, '0, 1'b1, '0));
            return;
          end
          if (sub_keys[i] == '0) open_slot = i;
        end
        if (open_slot < 0) begin
          pending_results.push_back(make_beat(ST_FULL, '0, 1'b1, '0));
        end else begin
          sub_keys[open_slot] = key;
          q_head[open_slot] = 0;
          q_fill[open_slot] = 0;
          pending_results.push_back(make_beat(ST_OK, '0, 1'b1, '0));
        end
      end
      OP_REMOVE: begin
        if (key != '0)
          for (int i = 0; i < SLOTS; i++)
            if (sub_keys[i] == key) sub_keys[i] = '0;
        pending_results.push_back(make_beat(ST_OK, '0, 1'b1, '0));
      end
      OP_BROADCAST: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (sub_keys[i] == '0) continue;
          // slow consumer gets evicted rather than queued
          if (q_fill[i] >= DEPTH) begin
            sub_keys[i] = '0;
            if (drop_count != '1) drop_count++;
            if (ev != 6'd63) ev++;
            continue;
          end
          pos = (q_head[i] + q_fill[i]) % DEPTH;
          q_words[i][pos] = msg;
          q_fill[i]++;
        end
        pending_results.push_back(make_beat(ST_OK, '0, 1'b1, ev));
      end
      default: begin
        if (key != '0)
          for (int i = 0; i < SLOTS; i++)
            if (sub_keys[i] == key && q_fill[i] != 0) begin
              slot = i;
              break;
            end
        if (slot < 0) begin
          pending_results.push_back(make_beat(ST_EMPTY, '0, 1'b1, '0));
        end else begin
          while (q_fill[slot] != 0 && pops < MAX_POPS) begin
            word = q_words[slot][q_head[slot]];
            q_head[slot] = (q_head[slot] + 1) % DEPTH;
            q_fill[slot]--;
            pops++;
            pending_results.push_back(make_beat(ST_OK, word,
                                                q_fill[slot] == 0 || pops == MAX_POPS, '0));
          end
        end
      end
    endcase
  endtask

  // offer one beat, with random idle cycles ahead of it, and predict on acceptance
  task automatic send_beat(op_t op, logic [KEY_W-1:0] key, logic [MSG_W-1:0] msg,
                           logic typed, status_t st);
    int depth_before;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    subscriber_key <= key;
    message <= msg;
    do @(posedge clk); while (in_stall);
    depth_before = pending_results.size();
    apply_command(op, key, msg);
    if (typed && pending_results[depth_before].st !== st) begin
      $display("%0t: status for op %s key %h: expected %s, predicted %s", $time,
               op.name(), key, st.name(), pending_results[depth_before].st.name());
      fails++;
    end
  endtask

  task automatic random_beat();
    int pick;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(99);
    key = ($urandom_range(19) == 0) ? 16'(($urandom_range(1) == 0) ? 0 : $urandom)
                                    : key_pool[$urandom_range(47)];
    if (pick < 25) send_beat(OP_ADD, key, '0, 1'b0, ST_OK);
    else if (pick < 35) send_beat(OP_REMOVE, key, {$urandom, $urandom}, 1'b0, ST_OK);
    else if (pick < 80) send_beat(OP_BROADCAST, key, {$urandom, $urandom}, 1'b0, ST_OK);
    else send_beat(OP_DRAIN, key, '0, 1'b0, ST_OK);
  endtask

  // one slow subscriber: fill its queue, drain it whole, then let it be evicted
  task automatic slow_consumer_burst();
    logic [KEY_W-1:0] key;
    key = key_pool[$urandom_range(47)];
    send_beat(OP_ADD, key, '0, 1'b0, ST_OK);
    repeat (DEPTH) send_beat(OP_BROADCAST, '0, {$urandom, $urandom}, 1'b0, ST_OK);
    send_beat(OP_DRAIN, key, '0, 1'b0, ST_OK);
    repeat (DEPTH + 1) send_beat(OP_BROADCAST, '0, {$urandom, $urandom}, 1'b0, ST_OK);
  endtask

  // receiver stall, with one long hold-off in the second random phase
  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    result_beat_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected beat status %0d msg %h", $time, status, message_out);
        fails++;
      end else begin
        e = pending_results.pop_front();
        if (status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status);
          fails++;
        end
        if (message_out !== e.msg) begin
          $display("%0t: message_out expected %h actual %h", $time, e.msg, message_out);
          fails++;
        end
        if (last !== e.last) begin
          $display("%0t: last expected %b actual %b", $time, e.last, last);
          fails++;
        end
        if (evicted_now !== e.evicted) begin
          $display("%0t: evicted_now expected %0d actual %0d", $time, e.evicted,
                   evicted_now);
          fails++;
        end
        if (dropped_total !== e.dropped) begin
          $display("%0t: dropped_total expected %0d actual %0d", $time, e.dropped,
                   dropped_total);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog timeout", $time);
      $display("multicast_subscriber_queues_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      sub_keys[i] = '0;
      q_head[i] = 0;
      q_fill[i] = 0;
    end
    drop_count = '0;
    key_pool[0] = 16'hFFFF;
    key_pool[1] = 16'h0001;
    for (int i = 2; i < 48; i++) key_pool[i] = 16'($urandom_range(65535, 1));
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i])
      send_beat(dir_rows[i].op, dir_rows[i].key, dir_rows[i].msg,
                dir_rows[i].typed, dir_rows[i].st);

    // random phases with differing idle and stall rates
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        3: begin idle_pct = 28; stall_pct = 28; end
        default: begin idle_pct = $urandom_range(30); stall_pct = $urandom_range(30); end
      endcase
      if (phase == 1) hold_cycles = 400;
      if (phase < 4) slow_consumer_burst();
      repeat (phase < 4 ? 18 : 20) random_beat();
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("multicast_subscriber_queues_test passed");
    end else begin
      $display("multicast_subscriber_queues_test failed");
    end
    $finish;
  end

endmodule
